// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent in this cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/mpcc_pkg.sv =====
package mpcc_pkg;

    // field widths fixed by the stream format
    localparam int SAMPLE_W   = 16;
    localparam int OFFSET_W   = 16;
    localparam int CARRIED_CH = 4;
    localparam int EXT_W      = SAMPLE_W + 1;
    localparam int SHIFT_W    = EXT_W + 1;
    localparam int DIFF_W     = SHIFT_W + 1;
    localparam int OUT_W      = 21;
    localparam int S_TDATA_W  = CARRIED_CH * SAMPLE_W;
    localparam int M_TDATA_W  = ((OUT_W + 7) / 8) * 8;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // defaults for the top-level parameters
    localparam int DEF_NUM_CHANNELS = 4;
    localparam int DEF_SAMPLE_BITS  = 16;

    // combine mode codes
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_PLAIN = 2'd0;
    localparam t_mode MODE_SUB   = 2'd1;
    localparam t_mode MODE_ADD   = 2'd2;

    // register indexes
    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_MODE      = 3'd0;
    localparam t_reg_idx REG_OFF_FIRST = 3'd1;
    localparam t_reg_idx REG_OFF_LAST  = 3'd4;

    // per-lane stage loads
    typedef struct packed {
        logic load1;
        logic load2;
    } t_lane_ctl;

    // merge stage loads
    typedef struct packed {
        logic load3;
        logic load4;
    } t_merge_ctl;

endpackage

// ===== rtl/mpcc_lane.sv =====
module mpcc_lane
    import mpcc_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                       i_clk,
    input  t_lane_ctl                  i_ctl,
    input  logic [SAMPLE_W-1:0]        i_sample,
    input  logic signed [OFFSET_W-1:0] i_offset,
    input  logic signed [SHIFT_W-1:0]  i_nbr_shifted,
    output logic signed [SHIFT_W-1:0]  o_shifted,
    output logic signed [SHIFT_W-1:0]  o_shifted_s2,
    output logic [DIFF_W-1:0]          o_absdiff
);

    // effective sign position; wider sample settings read the field as unsigned
    localparam int SB_EFF = (SAMPLE_BITS > SAMPLE_W) ? EXT_W : SAMPLE_BITS;
    localparam int SHAMT  = EXT_W - SB_EFF;

    logic [EXT_W-1:0]          w_ext;
    logic signed [EXT_W-1:0]   w_up;
    logic signed [EXT_W-1:0]   w_sx;
    logic signed [SHIFT_W-1:0] n_shifted;
    logic signed [SHIFT_W-1:0] r_shifted;
    logic signed [DIFF_W-1:0]  w_diff;
    logic [DIFF_W-1:0]         n_absdiff;
    logic [DIFF_W-1:0]         r_absdiff;
    logic signed [SHIFT_W-1:0] r_shifted_s2;

    // sign extension from the configured sample width, then offset
    always_comb begin
        w_ext     = {1'b0, i_sample};
        w_up      = $signed(w_ext << SHAMT);
        w_sx      = w_up >>> SHAMT;
        n_shifted = SHIFT_W'(w_sx) + SHIFT_W'(i_offset);
    end

    // absolute difference against the cyclic neighbour
    always_comb begin
        w_diff    = DIFF_W'(i_nbr_shifted) - DIFF_W'(r_shifted);
        n_absdiff = w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load1) begin
            r_shifted <= n_shifted;
        end
        if (i_ctl.load2) begin
            r_absdiff    <= n_absdiff;
            r_shifted_s2 <= r_shifted;
        end
    end

    assign o_shifted    = r_shifted;
    assign o_shifted_s2 = r_shifted_s2;
    assign o_absdiff    = r_absdiff;

endmodule

// ===== rtl/mpcc_merge.sv =====
module mpcc_merge
    import mpcc_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic                      i_clk,
    input  t_merge_ctl                i_ctl,
    input  t_mode                     i_mode,
    input  logic signed [SHIFT_W-1:0] i_shifted [NUM_CHANNELS],
    input  logic [DIFF_W-1:0]         i_absdiff [NUM_CHANNELS],
    output logic [OUT_W-1:0]          o_value
);

    logic [OUT_W-1:0] n_sum;
    logic [OUT_W-1:0] n_diffs;
    logic [OUT_W-1:0] r_sum;
    logic [OUT_W-1:0] r_diffs;
    logic [OUT_W-1:0] n_value;
    logic [OUT_W-1:0] r_value;

    // lane sums, wrapping at the output width
    always_comb begin
        n_sum   = '0;
        n_diffs = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            n_sum   = n_sum + OUT_W'(i_shifted[c]);
            n_diffs = n_diffs + OUT_W'(i_absdiff[c]);
        end
    end

    // artefact correction by mode
    always_comb begin
        case (i_mode)
            MODE_SUB: n_value = r_sum - r_diffs;
            MODE_ADD: n_value = r_sum + r_diffs;
            default:  n_value = r_sum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load3) begin
            r_sum   <= n_sum;
            r_diffs <= n_diffs;
        end
        if (i_ctl.load4) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

// ===== rtl/multichannel_pixel_crossval_combine_core.sv =====
// Combines one pixel from up to four image stacks per transfer: each sample is
// sign-extended, shifted by its channel offset, and the shifted values are summed;
// the sum of absolute differences between cyclically neighbouring channels is then
// subtracted (mode 1), added (mode 2) or ignored (modes 0 and 3). The result wraps
// to 21 bits. One pixel is taken every clock cycle unless the output stalls; a result
// passes through two lane stages, a summing stage and the output register. Each
// stage holds only while the stage after it is full and stalled, so bubbles close up
// and the input keeps accepting while a finished result waits on the output.
// Offsets and mode are set over the register port; the user must set them while the
// stream is idle, which the block does not enforce. Channels past the fourth read as zero.
`include "assert_macros.svh"

module multichannel_pixel_crossval_combine_core
    import mpcc_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // stream in
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,  // sample_ch0, sample_ch1, sample_ch2, sample_ch3
    input  logic                  i_s_axis_tlast,  // slice_end
    // stream out
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,  // combined_value, zero pad
    output logic                  o_m_axis_tlast,  // slice_end_out
    // register port
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready
);

    localparam int LANE_IDX_W = (CARRIED_CH > 1) ? $clog2(CARRIED_CH) : 1;

    t_mode                     r_mode;
    logic signed [OFFSET_W-1:0] r_offset [CARRIED_CH];
    t_reg_idx                  w_idx;
    logic                      w_wr;
    logic [LANE_IDX_W-1:0]     w_slot;

    logic r_v1, r_v2, r_v3, r_v4;
    logic r_l1, r_l2, r_l3, r_l4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    t_lane_ctl  w_lane_ctl;
    t_merge_ctl w_merge_ctl;

    logic [SAMPLE_W-1:0]        w_sample   [NUM_CHANNELS];
    logic signed [OFFSET_W-1:0] w_offset   [NUM_CHANNELS];
    logic signed [SHIFT_W-1:0]  w_shifted  [NUM_CHANNELS];
    logic signed [SHIFT_W-1:0]  w_shift_s2 [NUM_CHANNELS];
    logic [DIFF_W-1:0]          w_absdiff  [NUM_CHANNELS];
    logic [OUT_W-1:0]           w_value;

    // register decode
    assign w_idx    = i_paddr[APB_ADDR_W-1:2];
    assign w_wr     = i_psel & i_penable & i_pwrite;
    assign w_slot   = LANE_IDX_W'(w_idx - REG_OFF_FIRST);
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            for (int c = 0; c < CARRIED_CH; c++) begin
                r_offset[c] <= '0;
            end
        end else if (w_wr) begin
            if (w_idx == REG_MODE) begin
                r_mode <= t_mode'(i_pwdata[1:0]);
            end else if (w_idx inside {[REG_OFF_FIRST:REG_OFF_LAST]}) begin
                r_offset[w_slot] <= $signed(i_pwdata[OFFSET_W-1:0]);
            end
        end
    end

    // register read back
    always_comb begin
        o_prdata = '0;
        if (w_idx == REG_MODE) begin
            o_prdata = APB_DATA_W'(r_mode);
        end else if (w_idx inside {[REG_OFF_FIRST:REG_OFF_LAST]}) begin
            o_prdata = APB_DATA_W'(r_offset[w_slot]);
        end
    end

    // stage flow: a stage moves when it is empty or the next one moves
    assign w_rdy4          = !r_v4 || i_m_axis_tready;
    assign w_rdy3          = !r_v3 || w_rdy4;
    assign w_rdy2          = !r_v2 || w_rdy3;
    assign w_rdy1          = !r_v1 || w_rdy2;
    assign o_s_axis_tready = w_rdy1;

    assign w_lane_ctl.load1  = w_rdy1 && i_s_axis_tvalid;
    assign w_lane_ctl.load2  = w_rdy2 && r_v1;
    assign w_merge_ctl.load3 = w_rdy3 && r_v2;
    assign w_merge_ctl.load4 = w_rdy4 && r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_s_axis_tvalid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // slice end flag travels beside the data
    always_ff @(posedge i_clk) begin
        if (w_lane_ctl.load1)  r_l1 <= i_s_axis_tlast;
        if (w_lane_ctl.load2)  r_l2 <= r_l1;
        if (w_merge_ctl.load3) r_l3 <= r_l2;
        if (w_merge_ctl.load4) r_l4 <= r_l3;
    end

    // one lane per channel, neighbour taken cyclically
    for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
        if (c < CARRIED_CH) begin : g_carried
            assign w_sample[c] = i_s_axis_tdata[c*SAMPLE_W +: SAMPLE_W];
            assign w_offset[c] = r_offset[c];
        end else begin : g_empty
            assign w_sample[c] = '0;
            assign w_offset[c] = '0;
        end

        mpcc_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .i_clk         (i_clk),
            .i_ctl         (w_lane_ctl),
            .i_sample      (w_sample[c]),
            .i_offset      (w_offset[c]),
            .i_nbr_shifted (w_shifted[(c + 1) % NUM_CHANNELS]),
            .o_shifted     (w_shifted[c]),
            .o_shifted_s2  (w_shift_s2[c]),
            .o_absdiff     (w_absdiff[c])
        );
    end

    // merge of lane results
    mpcc_merge #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_ctl     (w_merge_ctl),
        .i_mode    (r_mode),
        .i_shifted (w_shift_s2),
        .i_absdiff (w_absdiff),
        .o_value   (w_value)
    );

    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = M_TDATA_W'(w_value);
    assign o_m_axis_tlast  = r_l4;

    // an empty output stage never blocks the input
    `ASSERT_ALWAYS(a_rdy_when_out_empty, i_clk, i_rst_n, r_v4 || o_s_axis_tready)
    // a stalled result is not dropped
    `ASSERT_NEXT(a_out_kept, i_clk, i_rst_n, r_v4 && !i_m_axis_tready, r_v4)
    // an accepted pixel always lands in the first stage
    `ASSERT_NEXT(a_in_lands, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_v1)
    // the output stage fills only from a full summing stage
    `ASSERT_NEXT(a_out_from_s3, i_clk, i_rst_n, !r_v3 && !r_v4, !r_v4)

endmodule
